FILE: design/cbsg_pkg.sv
`timescale 1ns / 1ps

package cbsg_pkg;

   // Default number of hyperprior words in the store.
   localparam int CBSG_STORE_DEPTH = 4096;

   // Configuration port address width: seven 32-bit registers.
   localparam int CSR_ADDR_W = 5;

   // Fraction bits of the reciprocal used for the small divisions.
   localparam int RECIP_SHIFT = 15;

   // Input operation codes.
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_CHAN_OFFSET    = 3'd0,
      CSR_BASE_LIMIT     = 3'd1,
      CSR_CHANNEL_REPEAT = 3'd2,
      CSR_PIXEL_REPEAT   = 3'd3,
      CSR_GRID_HEIGHT    = 3'd4,
      CSR_GRID_WIDTH     = 3'd5,
      CSR_SCALE_MAX      = 3'd6
   } csr_index_type;

   // Register values after reset.
   localparam logic [8:0] RST_CHAN_OFFSET    = 9'd1;
   localparam logic [8:0] RST_BASE_LIMIT     = 9'd1;
   localparam logic [4:0] RST_CHANNEL_REPEAT = 5'd1;
   localparam logic [4:0] RST_PIXEL_REPEAT   = 5'd1;
   localparam logic [8:0] RST_GRID_HEIGHT    = 9'd1;
   localparam logic [8:0] RST_GRID_WIDTH     = 9'd1;
   localparam logic [9:0] RST_SCALE_MAX      = 10'd63;

   // Configuration register file contents.
   typedef struct packed {
      logic [8:0] chan_offset;
      logic [8:0] base_limit;
      logic [4:0] channel_repeat;
      logic [4:0] pixel_repeat;
      logic [8:0] grid_height;
      logic [8:0] grid_width;
      logic [9:0] scale_max;
   } cfg_type;

   // Control flags that travel with each transaction down the pipeline.
   typedef struct packed {
      logic query;  // Query when set, load otherwise.
      logic bad;    // Invalid mapping for a query, out-of-range address for a load.
      logic odd;    // Odd checkerboard position.
   } item_ctl_type;

   // Rounded-up reciprocals 2^15/d for divisors 0..31; zero divides as one.
   // Exact quotients for dividends below 1024.
   localparam logic [15:0] RECIP_TABLE [32] = '{
      16'd32768, 16'd32768, 16'd16384, 16'd10923, 16'd8192, 16'd6554, 16'd5462, 16'd4682,
      16'd4096,  16'd3641,  16'd3277,  16'd2979,  16'd2731, 16'd2521, 16'd2341, 16'd2185,
      16'd2048,  16'd1928,  16'd1821,  16'd1725,  16'd1639, 16'd1561, 16'd1490, 16'd1425,
      16'd1366,  16'd1311,  16'd1261,  16'd1214,  16'd1171, 16'd1130, 16'd1093, 16'd1058
   };

   // A zero grid dimension counts as one.
   function automatic logic [8:0] nonzero9(input logic [8:0] v);
      return (v == 9'd0) ? 9'd1 : v;
   endfunction

endpackage

FILE: design/cbsg_ifs.sv
`timescale 1ns / 1ps

// Input channel: loads and queries.
interface cbsg_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [11:0] store_address;
   logic [15:0] half_word;
   logic [7:0]  channel;
   logic [9:0]  row;
   logic [9:0]  col;

   modport source (output valid, op, store_address, half_word, channel, row, col,
                   input ready);
   modport sink   (input valid, op, store_address, half_word, channel, row, col,
                   output ready);
endinterface

// Result channel: one transaction per query.
interface cbsg_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] scale_first;
   logic [9:0] scale_second;
   logic       mapping_error;

   modport source (output valid, scale_first, scale_second, mapping_error, input ready);
   modport sink   (input valid, scale_first, scale_second, mapping_error, output ready);
endinterface

FILE: design/cbsg_ram.sv
`timescale 1ns / 1ps

module cbsg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports that hold while rd_en is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: design/cbsg_csr.sv
`timescale 1ns / 1ps

module cbsg_csr import cbsg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite && pready;

   // Register write decode; an index past the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_CHAN_OFFSET:    cfg_in.chan_offset    = pwdata[8:0];
            CSR_BASE_LIMIT:     cfg_in.base_limit     = pwdata[8:0];
            CSR_CHANNEL_REPEAT: cfg_in.channel_repeat = pwdata[4:0];
            CSR_PIXEL_REPEAT:   cfg_in.pixel_repeat   = pwdata[4:0];
            CSR_GRID_HEIGHT:    cfg_in.grid_height    = pwdata[8:0];
            CSR_GRID_WIDTH:     cfg_in.grid_width     = pwdata[8:0];
            CSR_SCALE_MAX:      cfg_in.scale_max      = pwdata[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chan_offset    <= RST_CHAN_OFFSET;
         cfg_ff.base_limit     <= RST_BASE_LIMIT;
         cfg_ff.channel_repeat <= RST_CHANNEL_REPEAT;
         cfg_ff.pixel_repeat   <= RST_PIXEL_REPEAT;
         cfg_ff.grid_height    <= RST_GRID_HEIGHT;
         cfg_ff.grid_width     <= RST_GRID_WIDTH;
         cfg_ff.scale_max      <= RST_SCALE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      case (index)
         CSR_CHAN_OFFSET:    prdata = 32'(cfg_ff.chan_offset);
         CSR_BASE_LIMIT:     prdata = 32'(cfg_ff.base_limit);
         CSR_CHANNEL_REPEAT: prdata = 32'(cfg_ff.channel_repeat);
         CSR_PIXEL_REPEAT:   prdata = 32'(cfg_ff.pixel_repeat);
         CSR_GRID_HEIGHT:    prdata = 32'(cfg_ff.grid_height);
         CSR_GRID_WIDTH:     prdata = 32'(cfg_ff.grid_width);
         CSR_SCALE_MAX:      prdata = 32'(cfg_ff.scale_max);
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/cbsg_index.sv
`timescale 1ns / 1ps

// Four-stage address pipeline: divide, clamp and scale by height,
// scale by width, final add and range check.
module cbsg_index import cbsg_pkg::*; #(
   parameter int STORE_DEPTH = CBSG_STORE_DEPTH,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_op,
   input  logic [11:0]   in_store_address,
   input  logic [15:0]   in_half_word,
   input  logic [7:0]    in_channel,
   input  logic [9:0]    in_row,
   input  logic [9:0]    in_col,
   output logic          out_valid,
   input  logic          out_ready,
   output item_ctl_type  out_ctl,
   output logic [AW-1:0] out_addr0,
   output logic [AW-1:0] out_addr1,
   output logic [15:0]   out_word
);

   localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);

   logic rdy_a, rdy_b, rdy_c, rdy_d;

   // Stage A: quotients by reciprocal multiplication.
   logic         va_ff;
   item_ctl_type ctl_a_ff, ctl_a_in;
   logic [11:0]  ld_a_ff;
   logic [15:0]  word_a_ff;
   logic [25:0]  pch0_a_ff, pch1_a_ff, prow_a_ff, pcol_a_ff;
   logic [25:0]  pch0_in, pch1_in, prow_in, pcol_in;
   logic [15:0]  cr_recip, sr_recip;
   logic [9:0]   ch1;

   // Stage B: clamped cells and base times grid height.
   logic         vb_ff;
   item_ctl_type ctl_b_ff, ctl_b_in;
   logic [11:0]  ld_b_ff;
   logic [15:0]  word_b_ff;
   logic [18:0]  bg0_b_ff, bg1_b_ff, bg0_in, bg1_in;
   logic [8:0]   zy_b_ff, zx_b_ff, zy_in, zx_in;
   logic [9:0]   base0, base1, zy_q, zx_q;
   logic [8:0]   gh, gw, gh_m1, gw_m1;

   // Stage C: row index times grid width.
   logic         vc_ff;
   item_ctl_type ctl_c_ff;
   logic [11:0]  ld_c_ff;
   logic [15:0]  word_c_ff;
   logic [28:0]  pc0_c_ff, pc1_c_ff, pc0_in, pc1_in;
   logic [8:0]   zx_c_ff;
   logic [19:0]  r0, r1;

   // Stage D: final addresses and range checks.
   logic         vd_ff;
   item_ctl_type ctl_d_ff, ctl_d_in;
   logic [AW-1:0] addr0_d_ff, addr1_d_ff, addr0_in, addr1_in;
   logic [15:0]  word_d_ff;
   logic [29:0]  a0, a1;
   logic [31:0]  ld_w;

   // Each stage moves when it is empty or the next one moves.
   assign rdy_d    = !vd_ff || out_ready;
   assign rdy_c    = !vc_ff || rdy_d;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   // Stage A logic.
   always_comb begin
      cr_recip       = RECIP_TABLE[cfg.channel_repeat];
      sr_recip       = RECIP_TABLE[cfg.pixel_repeat];
      ch1            = 10'(in_channel) + 10'(cfg.chan_offset);
      pch0_in        = 26'(in_channel) * 26'(cr_recip);
      pch1_in        = 26'(ch1) * 26'(cr_recip);
      prow_in        = 26'(in_row) * 26'(sr_recip);
      pcol_in        = 26'(in_col) * 26'(sr_recip);
      ctl_a_in.query = (in_op == OP_QUERY);
      ctl_a_in.bad   = 1'b0;
      ctl_a_in.odd   = in_row[0] ^ in_col[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (rdy_a) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         ctl_a_ff  <= ctl_a_in;
         ld_a_ff   <= in_store_address;
         word_a_ff <= in_half_word;
         pch0_a_ff <= pch0_in;
         pch1_a_ff <= pch1_in;
         prow_a_ff <= prow_in;
         pcol_a_ff <= pcol_in;
      end
   end

   // Stage B logic: clamp the cell to the grid and check the base channels.
   always_comb begin
      base0        = pch0_a_ff[RECIP_SHIFT+9:RECIP_SHIFT];
      base1        = pch1_a_ff[RECIP_SHIFT+9:RECIP_SHIFT];
      zy_q         = prow_a_ff[RECIP_SHIFT+9:RECIP_SHIFT];
      zx_q         = pcol_a_ff[RECIP_SHIFT+9:RECIP_SHIFT];
      gh           = nonzero9(cfg.grid_height);
      gw           = nonzero9(cfg.grid_width);
      gh_m1        = gh - 9'd1;
      gw_m1        = gw - 9'd1;
      zy_in        = (zy_q > 10'(gh_m1)) ? gh_m1 : zy_q[8:0];
      zx_in        = (zx_q > 10'(gw_m1)) ? gw_m1 : zx_q[8:0];
      bg0_in       = 19'(base0) * 19'(gh);
      bg1_in       = 19'(base1) * 19'(gh);
      ctl_b_in     = ctl_a_ff;
      ctl_b_in.bad = (base0 >= 10'(cfg.base_limit)) || (base1 >= 10'(cfg.base_limit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (rdy_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b && va_ff) begin
         ctl_b_ff  <= ctl_b_in;
         ld_b_ff   <= ld_a_ff;
         word_b_ff <= word_a_ff;
         bg0_b_ff  <= bg0_in;
         bg1_b_ff  <= bg1_in;
         zy_b_ff   <= zy_in;
         zx_b_ff   <= zx_in;
      end
   end

   // Stage C logic: add the row cell, multiply by the grid width.
   always_comb begin
      r0     = 20'(bg0_b_ff) + 20'(zy_b_ff);
      r1     = 20'(bg1_b_ff) + 20'(zy_b_ff);
      pc0_in = 29'(r0) * 29'(gw);
      pc1_in = 29'(r1) * 29'(gw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (rdy_c) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c && vb_ff) begin
         ctl_c_ff  <= ctl_b_ff;
         ld_c_ff   <= ld_b_ff;
         word_c_ff <= word_b_ff;
         pc0_c_ff  <= pc0_in;
         pc1_c_ff  <= pc1_in;
         zx_c_ff   <= zx_b_ff;
      end
   end

   // Stage D logic: a load takes its own address, a query the computed ones.
   always_comb begin
      a0       = 30'(pc0_c_ff) + 30'(zx_c_ff);
      a1       = 30'(pc1_c_ff) + 30'(zx_c_ff);
      ld_w     = 32'(ld_c_ff);
      ctl_d_in = ctl_c_ff;
      addr1_in = a1[AW-1:0];
      if (ctl_c_ff.query) begin
         addr0_in     = a0[AW-1:0];
         ctl_d_in.bad = ctl_c_ff.bad || (32'(a0) >= DEPTH_W) || (32'(a1) >= DEPTH_W);
      end else begin
         addr0_in     = ld_w[AW-1:0];
         ctl_d_in.bad = (ld_w >= DEPTH_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (rdy_d) begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d && vc_ff) begin
         ctl_d_ff   <= ctl_d_in;
         addr0_d_ff <= addr0_in;
         addr1_d_ff <= addr1_in;
         word_d_ff  <= word_c_ff;
      end
   end

   assign out_valid = vd_ff;
   assign out_ctl   = ctl_d_ff;
   assign out_addr0 = addr0_d_ff;
   assign out_addr1 = addr1_d_ff;
   assign out_word  = word_d_ff;

endmodule

FILE: design/cbsg_scale.sv
`timescale 1ns / 1ps

// Half to scale conversion, checkerboard swap and the result register.
module cbsg_scale import cbsg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [9:0]   scale_max,
   input  logic         in_valid,
   output logic         in_ready,
   input  item_ctl_type in_ctl,
   input  logic [15:0]  in_word_a,
   input  logic [15:0]  in_word_b,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [9:0]   out_scale_first,
   output logic [9:0]   out_scale_second,
   output logic         out_mapping_error
);

   logic       out_valid_ff;
   logic [9:0] first_ff, second_ff, first_in, second_in;
   logic       error_ff;
   logic [9:0] scale_a, scale_b;

   // |v| truncated to an integer and clamped. Exponents of 25 and up,
   // infinity and NaN included, are at least 1024 and saturate.
   function automatic logic [9:0] half_to_scale(input logic [15:0] h,
                                                input logic [9:0]  smax);
      logic [4:0]  e;
      logic [4:0]  sh;
      logic [10:0] v;
      e  = h[14:10];
      sh = 5'd25 - e;
      v  = {1'b1, h[9:0]} >> sh;
      if (e >= 5'd25) begin
         return smax;
      end else if (e < 5'd15) begin
         return 10'd0;
      end else if (v > 11'(smax)) begin
         return smax;
      end else begin
         return v[9:0];
      end
   endfunction

   assign in_ready = !out_valid_ff || out_ready;

   // Swap on odd positions; an invalid mapping gives zero scales.
   always_comb begin
      scale_a = half_to_scale(in_word_a, scale_max);
      scale_b = half_to_scale(in_word_b, scale_max);
      if (in_ctl.bad) begin
         first_in  = 10'd0;
         second_in = 10'd0;
      end else if (in_ctl.odd) begin
         first_in  = scale_b;
         second_in = scale_a;
      end else begin
         first_in  = scale_a;
         second_in = scale_b;
      end
   end

   // Loads end here without a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid && in_ctl.query;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid && in_ctl.query) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         error_ff  <= in_ctl.bad;
      end
   end

   assign out_valid         = out_valid_ff;
   assign out_scale_first   = first_ff;
   assign out_scale_second  = second_ff;
   assign out_mapping_error = error_ff;

endmodule

FILE: design/checkerboard_scale_gather.sv
// A query passes the four index stages, the store read stage and the result register.
// Throughput: one transaction per cycle, loads and queries alike, while the result is
// taken; a load makes no result. The rate is set by the six-stage pipeline and the
// two-read-port store, whose registered reads form the fifth stage.
// Reset is synchronous and active high: it empties the pipeline and restores the
// register defaults; the store keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps

module checkerboard_scale_gather import cbsg_pkg::*; #(
   parameter int STORE_DEPTH = CBSG_STORE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   cbsg_req_if.sink              req_chan,
   cbsg_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW = $clog2(STORE_DEPTH);

   cfg_type       cfg;
   logic          d_valid, d_ready;
   item_ctl_type  d_ctl;
   logic [AW-1:0] d_addr0, d_addr1;
   logic [15:0]   d_word;
   logic          ve_ff;
   item_ctl_type  ctl_e_ff;
   logic          e_ready, f_ready;
   logic          wr_en;
   logic [15:0]   word_a, word_b;

   cbsg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cbsg_index #(.STORE_DEPTH(STORE_DEPTH)) u_index (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (req_chan.valid),
      .in_ready         (req_chan.ready),
      .in_op            (req_chan.op),
      .in_store_address (req_chan.store_address),
      .in_half_word     (req_chan.half_word),
      .in_channel       (req_chan.channel),
      .in_row           (req_chan.row),
      .in_col           (req_chan.col),
      .out_valid        (d_valid),
      .out_ready        (d_ready),
      .out_ctl          (d_ctl),
      .out_addr0        (d_addr0),
      .out_addr1        (d_addr1),
      .out_word         (d_word)
   );

   // Store access stage: loads write as they enter, queries read both words.
   assign e_ready = !ve_ff || f_ready;
   assign d_ready = e_ready;
   assign wr_en   = d_valid && e_ready && !d_ctl.query && !d_ctl.bad;

   cbsg_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (d_addr0),
      .wr_data   (d_word),
      .rd_en     (e_ready),
      .rd_addr_a (d_addr0),
      .rd_addr_b (d_addr1),
      .rd_data_a (word_a),
      .rd_data_b (word_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (e_ready) begin
         ve_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready && d_valid) begin
         ctl_e_ff <= d_ctl;
      end
   end

   cbsg_scale u_scale (
      .clock             (clock),
      .reset             (reset),
      .scale_max         (cfg.scale_max),
      .in_valid          (ve_ff),
      .in_ready          (f_ready),
      .in_ctl            (ctl_e_ff),
      .in_word_a         (word_a),
      .in_word_b         (word_b),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .out_scale_first   (rsp_chan.scale_first),
      .out_scale_second  (rsp_chan.scale_second),
      .out_mapping_error (rsp_chan.mapping_error)
   );

endmodule

FILE: design/cbsg_checker.sv
`timescale 1ns / 1ps

module cbsg_checker import cbsg_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [9:0]            scale_first,
   input logic [9:0]            scale_second,
   input logic                  mapping_error,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic                  pready,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [31:0]           pwdata
);

   logic [9:0] scale_max_ff;
   logic [9:0] scale_max_in;

   // Shadow copy of the scale limit as written through the port.
   always_comb begin
      scale_max_in = scale_max_ff;
      if (psel && penable && pwrite && pready &&
          (paddr[CSR_ADDR_W-1:2] == CSR_SCALE_MAX)) begin
         scale_max_in = pwdata[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_max_ff <= RST_SCALE_MAX;
      end else begin
         scale_max_ff <= scale_max_in;
      end
   end

   // The result channel is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input backpressure only comes from a full pipeline behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
                    !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while the result side is free");

   // An invalid mapping carries zero scales.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && mapping_error) |-> (scale_first == 10'd0 &&
                                                      scale_second == 10'd0))
      else $error("nonzero scale on a mapping error");

   // Scales never exceed the configured limit.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !mapping_error) |-> (scale_first <= scale_max_ff &&
                                                       scale_second <= scale_max_ff))
      else $error("scale above the configured limit");

   // A stalled result transaction holds.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(scale_first) &&
                                                   $stable(scale_second) &&
                                                   $stable(mapping_error)))
      else $error("result changed while stalled");

endmodule

bind checkerboard_scale_gather cbsg_checker u_cbsg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .scale_first   (rsp_chan.scale_first),
   .scale_second  (rsp_chan.scale_second),
   .mapping_error (rsp_chan.mapping_error),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .pready        (pready),
   .paddr         (paddr),
   .pwdata        (pwdata)
);
